// ===== design/leg_linkage_forward_kinematics_unit_defines.svh =====
// assertion macros shared by the leg kinematics rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef LEG_LINKAGE_FORWARD_KINEMATICS_UNIT_DEFINES_SVH
`define LEG_LINKAGE_FORWARD_KINEMATICS_UNIT_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define LFK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfk assertion failed");

// consequent checked in the same cycle
`define LFK_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfk assertion failed");

`endif

// ===== design/lfk_pkg.sv =====
// types, constants and helper functions for the leg kinematics unit
// no dependencies
`default_nettype none
package lfk_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_W       = 5;
  localparam int XW            = 34;
  localparam int ZW            = 28;
  localparam int SIDE_W        = ZW + 2;
  localparam int AW            = 20;
  localparam int MW            = 17;

  localparam logic signed [AW-1:0] FULL_TURN    = 20'sd92160;
  localparam logic signed [AW-1:0] HALF_TURN    = 20'sd46080;
  localparam logic signed [AW-1:0] QUARTER_TURN = 20'sd23040;
  localparam logic signed [XW-1:0] INV_GAIN     = 34'sd652032874;
  localparam logic signed [28:0]   DEG_TO_RAD   = 29'sd74961321;

  typedef enum logic [1:0] {
    REG_UPPER  = 2'd0,
    REG_LOWER  = 2'd1,
    REG_OFFSET = 2'd2,
    REG_NONE   = 2'd3
  } lfk_reg_e;

  typedef struct packed {
    logic                  vld;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic [SIDE_W-1:0]     side;
  } lfk_beat_t;

  typedef struct packed {
    logic                 flip;
    logic signed [MW-1:0] m;
  } lfk_red_t;

  function automatic logic signed [ZW-1:0] lfk_atan(input logic [STAGE_W-1:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // wrap into -90..90 degrees, flip marks a half-turn taken out
  function automatic lfk_red_t lfk_reduce(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] m;
    lfk_red_t r;
    m = a;
    if (m > HALF_TURN) m = m - FULL_TURN;
    if (m > HALF_TURN) m = m - FULL_TURN;
    if (m <= -HALF_TURN) m = m + FULL_TURN;
    if (m <= -HALF_TURN) m = m + FULL_TURN;
    r.flip = 1'b0;
    if (m > QUARTER_TURN) begin
      m = m - HALF_TURN;
      r.flip = 1'b1;
    end else if (m < -QUARTER_TURN) begin
      m = m + HALF_TURN;
      r.flip = 1'b1;
    end
    r.m = m[MW-1:0];
    return r;
  endfunction

  // 1/256 degree to 2^-24 rad, rounded
  function automatic logic signed [ZW-1:0] lfk_to_rad(input logic signed [MW-1:0] m);
    logic signed [45:0] p;
    p = 46'(m) * 46'(DEG_TO_RAD) + 46'sd32768;
    return p[16+ZW-1:16];
  endfunction

  // round half away from zero to mm, then clamp
  function automatic logic signed [9:0] lfk_to_mm(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] a;
    logic signed [XW-1:0] r;
    a = (v < 0) ? -v : v;
    a = (a + (XW'(1) <<< 17)) >>> 18;
    r = (v < 0) ? -a : a;
    if (r > 34'sd511) r = 34'sd511;
    if (r < -34'sd512) r = -34'sd512;
    return r[9:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/lfk_cordic_cell.sv =====
// one cordic rotation step with its own output register
// depends on lfk_pkg
`default_nettype none
module lfk_cordic_cell import lfk_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic [STAGE_W-1:0] stage_i,
  input  wire lfk_beat_t          beat_i,
  output lfk_beat_t               beat_o
);

  logic                 vld_q;
  lfk_beat_t            data_d, data_q;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = beat_i.x >>> stage_i;
    dy = beat_i.y >>> stage_i;
    data_d = beat_i;
    if (beat_i.z >= 0) begin
      data_d.x = beat_i.x - dy;
      data_d.y = beat_i.y + dx;
      data_d.z = beat_i.z - lfk_atan(stage_i);
    end else begin
      data_d.x = beat_i.x + dy;
      data_d.y = beat_i.y - dx;
      data_d.z = beat_i.z + lfk_atan(stage_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    beat_o     = data_q;
    beat_o.vld = vld_q;
  end

endmodule
`default_nettype wire

// ===== design/lfk_cordic_chain.sv =====
// row of cordic cells, one rotation step per cell
// depends on lfk_pkg and lfk_cordic_cell
`default_nettype none
module lfk_cordic_chain import lfk_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire lfk_beat_t beat_i,
  output lfk_beat_t      beat_o
);

  lfk_beat_t link [CORDIC_STAGES+1];

  assign link[0] = beat_i;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    lfk_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .stage_i(STAGE_W'(g)),
      .beat_i (link[g]),
      .beat_o (link[g+1])
    );
  end

  assign beat_o = link[CORDIC_STAGES];

endmodule
`default_nettype wire

// ===== design/leg_linkage_forward_kinematics_unit.sv =====
// Leg forward kinematics: registered angle reduction, radian scaling, alpha
// cordic row, foot vector, gain correction, beta row, output; throughput one
// beat per cycle, set by both rows, each cell one rotation step per cycle.
// The whole pipeline holds while the output beat is stalled.
// Reset clears all valid bits and loads the default link geometry.
// depends on lfk_pkg, lfk_cordic_chain and the defines header
`default_nettype none
`include "leg_linkage_forward_kinematics_unit_defines.svh"
module leg_linkage_forward_kinematics_unit import lfk_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_addr_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [16:0] hip_angle_i,
  input  wire logic signed [16:0] knee_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [9:0]       foot_along_o,
  output logic signed [9:0]       foot_across_o
);

  logic [11:0] upper_q, lower_q;
  logic [15:0] offset_q;
  logic        adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= 12'd1995;
      lower_q  <= 12'd2080;
      offset_q <= 16'd41772;
    end else if (cfg_we_i) begin
      unique case (lfk_reg_e'(cfg_addr_i))
        REG_UPPER:  upper_q  <= cfg_wdata_i[11:0];
        REG_LOWER:  lower_q  <= cfg_wdata_i[11:0];
        REG_OFFSET: offset_q <= cfg_wdata_i;
        REG_NONE:   ;
        default:    ;
      endcase
    end
  end

  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // angle reduction
  logic signed [AW-1:0] alpha, beta;
  lfk_red_t             ra_q, rb_q;
  logic                 v1_q;

  assign alpha = HALF_TURN + AW'(hip_angle_i) + AW'(knee_angle_i) - AW'({1'b0, offset_q});
  assign beta  = QUARTER_TURN - AW'(hip_angle_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra_q <= lfk_reduce(alpha);
      rb_q <= lfk_reduce(beta);
    end
  end

  // angle scaling to radians
  logic signed [ZW-1:0] za_q, zb_q;
  logic                 fa_q, fb_q;
  logic                 v2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      za_q <= lfk_to_rad(ra_q.m);
      zb_q <= lfk_to_rad(rb_q.m);
      fa_q <= ra_q.flip;
      fb_q <= rb_q.flip;
    end
  end

  lfk_beat_t c1_in, c1_out;
  always_comb begin
    c1_in.vld  = v2_q;
    c1_in.x    = INV_GAIN;
    c1_in.y    = '0;
    c1_in.z    = za_q;
    c1_in.side = {zb_q, fb_q, fa_q};
  end

  lfk_cordic_chain u_chain_alpha (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .beat_i (c1_in),
    .beat_o (c1_out)
  );

  // foot vector in the AD frame
  logic signed [XW-1:0] cos_a, sin_abs;
  logic signed [46:0]   px_full, py_full;
  logic signed [28:0]   px_q, py_q;
  logic signed [ZW-1:0] z3_q;
  logic                 f3_q, v3_q;

  always_comb begin
    cos_a   = c1_out.side[0] ? -c1_out.x : c1_out.x;
    sin_abs = (c1_out.y < 0) ? -c1_out.y : c1_out.y;
    px_full = $signed({5'd0, lower_q, 30'd0}) - $signed({1'b0, upper_q}) * 47'(cos_a);
    py_full = -($signed({1'b0, upper_q}) * 47'(sin_abs));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= px_full[44:16];
      py_q <= py_full[44:16];
      z3_q <= c1_out.side[SIDE_W-1:2];
      f3_q <= c1_out.side[1];
    end
  end

  // gain correction
  logic signed [59:0]   sx_full, sy_full;
  logic signed [XW-1:0] sx_q, sy_q;
  logic signed [ZW-1:0] z4_q;
  logic                 f4_q, v4_q;

  assign sx_full = 60'(px_q) * 60'(INV_GAIN);
  assign sy_full = 60'(py_q) * 60'(INV_GAIN);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= XW'($signed(sx_full[59:30]));
      sy_q <= XW'($signed(sy_full[59:30]));
      z4_q <= z3_q;
      f4_q <= f3_q;
    end
  end

  lfk_beat_t c2_in, c2_out;
  always_comb begin
    c2_in.vld  = v4_q;
    c2_in.x    = sx_q;
    c2_in.y    = sy_q;
    c2_in.z    = z4_q;
    c2_in.side = {{(SIDE_W-1){1'b0}}, f4_q};
  end

  lfk_cordic_chain u_chain_beta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .beat_i (c2_in),
    .beat_o (c2_out)
  );

  // output register
  logic signed [XW-1:0] gx, gy;
  logic signed [9:0]    along_q, across_q;

  assign gx = c2_out.side[0] ? -c2_out.x : c2_out.x;
  assign gy = c2_out.side[0] ? -c2_out.y : c2_out.y;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      along_q  <= lfk_to_mm(gx);
      across_q <= lfk_to_mm(gy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= c1_out.vld;
      v4_q        <= v3_q;
      out_valid_q <= c2_out.vld;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign foot_along_o  = along_q;
  assign foot_across_o = across_q;

  `LFK_ASSERT_NEXT(a_hold_frozen, !adv, $stable({v1_q, v2_q, v3_q, v4_q}))
  `LFK_ASSERT_NEXT(a_in_to_s1, in_valid_i && !in_stall_o, v1_q)
  `LFK_ASSERT_NEXT(a_chain_to_out, c2_out.vld && adv, out_valid_o)

endmodule
`default_nettype wire
